### hw/rtl/sparse_table_range_minimum_defines.svh
// Assertion macros for the sparse table range-minimum block.
// Used by the top level; clocked on clk, reset by rst_n.
`ifndef SPARSE_TABLE_RANGE_MINIMUM_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MINIMUM_DEFINES_SVH

`ifndef ASSERT_OFF
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMQ_ASSERT(label, prop, msg)
`define RMQ_ASSERT_RST(label, prop, msg)
`endif

`endif

### hw/rtl/rmq_pkg.sv
// Shared types, constants and helper functions for the range-minimum block.
// No dependencies.
package rmq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVEL_COUNT  = 11;
  localparam int VALUE_W      = 16;

  localparam int IDX_W       = 10;
  localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W       = $clog2(LEVEL_COUNT);
  localparam int ADDR_W      = LVL_W + IDX_W;
  localparam int MEM_DEPTH   = LEVEL_COUNT * (2 ** IDX_W);

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QFILL_W     = $clog2(QDEPTH + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 last;
    logic [VALUE_W-1:0]   value;
    logic [IDX_W-1:0]     left;
    logic [IDX_W-1:0]     right;
    logic [IDX_W-1:0]     jidx;
    logic [LVL_W-1:0]     lvl;
    logic                 bad;
  } rmq_cmd_t;

  typedef struct packed {
    logic building;
    logic table_ready;
  } rmq_stat_t;

  function automatic logic [VALUE_W-1:0] smaller(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

  function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
    logic [LVL_W-1:0] p;
    p = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (x[k]) p = LVL_W'(k);
    end
    return p;
  endfunction

endpackage

### hw/rtl/rmq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rmq_front.sv
// Input side: decodes requests, precomputes query level and second window,
// and buffers them in a short queue. Depends on rmq_pkg.
module rmq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rmq_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            cmd_valid,
  output rmq_pkg::rmq_cmd_t               cmd,
  input  logic                            cmd_pop
);

  rmq_pkg::rmq_cmd_t                  dec;
  logic [rmq_pkg::IDX_W-1:0]          left;
  logic [rmq_pkg::IDX_W-1:0]          right;
  logic [rmq_pkg::CNT_W-1:0]          len;
  logic [rmq_pkg::CNT_W-1:0]          jfull;
  logic [rmq_pkg::LVL_W-1:0]          lvl;
  logic                               push;

  rmq_pkg::rmq_cmd_t                  q_r [rmq_pkg::QDEPTH];
  logic [rmq_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [rmq_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [rmq_pkg::QFILL_W-1:0]        fill_r, fill_nxt;

  assign left  = in_tdata[25:16];
  assign right = in_tdata[35:26];
  assign len   = {1'b0, right} - {1'b0, left} + rmq_pkg::CNT_W'(1);
  assign lvl   = rmq_pkg::floor_log2(len);
  assign jfull = {1'b0, right} + rmq_pkg::CNT_W'(1) - (rmq_pkg::CNT_W'(1) << lvl);

  always_comb begin
    unique case (in_tuser)
      rmq_pkg::OP_LOAD:  dec.kind = rmq_pkg::CMD_LOAD;
      rmq_pkg::OP_QUERY: dec.kind = rmq_pkg::CMD_QUERY;
      default:           dec.kind = rmq_pkg::CMD_LOAD;
    endcase
    dec.last  = in_tlast;
    dec.value = in_tdata[rmq_pkg::VALUE_W-1:0];
    dec.left  = left;
    dec.right = right;
    dec.jidx  = jfull[rmq_pkg::IDX_W-1:0];
    dec.lvl   = lvl;
    dec.bad   = (left > right) || (lvl > rmq_pkg::LVL_W'(rmq_pkg::LEVEL_COUNT - 1));
  end

  assign in_tready = (fill_r != rmq_pkg::QFILL_W'(rmq_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + rmq_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + rmq_pkg::QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + rmq_pkg::QFILL_W'(push) - rmq_pkg::QFILL_W'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

endmodule

### hw/rtl/rmq_back.sv
// Execution side: loads elements, builds the sparse table level by level,
// answers queries and holds the result register. Depends on rmq_pkg, rmq_ram.
module rmq_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  rmq_pkg::rmq_cmd_t                cmd,
  output logic                             cmd_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rmq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output rmq_pkg::rmq_stat_t               stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_A,
    ST_BUILD_B,
    ST_BUILD_W,
    ST_QUERY_B,
    ST_QUERY_C
  } state_t;

  state_t                             state_r, state_nxt;
  logic [rmq_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic                               ready_r, ready_nxt;
  logic [rmq_pkg::LVL_W-1:0]          lvl_r, lvl_nxt;
  logic [rmq_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [rmq_pkg::CNT_W-1:0]          span_r, span_nxt;
  logic [rmq_pkg::VALUE_W-1:0]        a_r, a_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [rmq_pkg::VALUE_W-1:0]        out_min_r, out_min_nxt;
  logic                               out_err_r, out_err_nxt;

  logic                               we, re;
  logic [rmq_pkg::ADDR_W-1:0]         waddr, raddr;
  logic [rmq_pkg::VALUE_W-1:0]        wdata, rdata;

  logic                               out_free;
  logic [rmq_pkg::CNT_W-1:0]          base_cnt;
  logic [rmq_pkg::CNT_W-1:0]          cnt_new;
  logic [rmq_pkg::CNT_W-1:0]          half;
  logic [rmq_pkg::CNT_W-1:0]          next_i;
  logic [rmq_pkg::CNT_W:0]            next_end;
  logic [rmq_pkg::CNT_W:0]            next_span;
  logic                               q_err;

  rmq_ram #(
    .WIDTH (rmq_pkg::VALUE_W),
    .DEPTH (rmq_pkg::MEM_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign base_cnt  = ready_r ? '0 : count_r;
  assign cnt_new   = (base_cnt < rmq_pkg::CNT_W'(rmq_pkg::MAX_ELEMENTS)) ?
                     base_cnt + rmq_pkg::CNT_W'(1) : base_cnt;
  assign half      = span_r >> 1;
  assign next_i    = {1'b0, idx_r} + rmq_pkg::CNT_W'(1);
  assign next_end  = {1'b0, next_i} + {1'b0, span_r};
  assign next_span = {span_r, 1'b0};
  assign q_err     = !ready_r || cmd.bad || ({1'b0, cmd.right} >= count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    span_nxt      = span_r;
    a_nxt         = a_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_min_nxt   = out_min_r;
    out_err_nxt   = out_err_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = '0;
    cmd_pop       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == rmq_pkg::CMD_LOAD) begin
          cmd_pop   = 1'b1;
          ready_nxt = 1'b0;
          count_nxt = cnt_new;
          if (base_cnt < rmq_pkg::CNT_W'(rmq_pkg::MAX_ELEMENTS)) begin
            we    = 1'b1;
            waddr = {rmq_pkg::LVL_W'(0), base_cnt[rmq_pkg::IDX_W-1:0]};
            wdata = cmd.value;
          end
          if (cmd.last) begin
            if (cnt_new < rmq_pkg::CNT_W'(2)) begin
              ready_nxt = 1'b1;
            end else begin
              lvl_nxt   = rmq_pkg::LVL_W'(1);
              idx_nxt   = '0;
              span_nxt  = rmq_pkg::CNT_W'(2);
              state_nxt = ST_BUILD_A;
            end
          end
        end else if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (q_err) begin
            out_valid_nxt = 1'b1;
            out_min_nxt   = '0;
            out_err_nxt   = 1'b1;
          end else begin
            re        = 1'b1;
            raddr     = {cmd.lvl, cmd.left};
            lvl_nxt   = cmd.lvl;
            idx_nxt   = cmd.jidx;
            state_nxt = ST_QUERY_B;
          end
        end
      end
      ST_BUILD_A: begin
        re        = 1'b1;
        raddr     = {lvl_r - rmq_pkg::LVL_W'(1), idx_r};
        state_nxt = ST_BUILD_B;
      end
      ST_BUILD_B: begin
        re        = 1'b1;
        raddr     = {lvl_r - rmq_pkg::LVL_W'(1), idx_r + half[rmq_pkg::IDX_W-1:0]};
        a_nxt     = rdata;
        state_nxt = ST_BUILD_W;
      end
      ST_BUILD_W: begin
        we    = 1'b1;
        waddr = {lvl_r, idx_r};
        wdata = rmq_pkg::smaller(a_r, rdata);
        if (next_end <= {1'b0, count_r}) begin
          idx_nxt   = next_i[rmq_pkg::IDX_W-1:0];
          state_nxt = ST_BUILD_A;
        end else if (lvl_r == rmq_pkg::LVL_W'(rmq_pkg::LEVEL_COUNT - 1) ||
                     next_span > {1'b0, count_r}) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r + rmq_pkg::LVL_W'(1);
          span_nxt  = next_span[rmq_pkg::CNT_W-1:0];
          idx_nxt   = '0;
          state_nxt = ST_BUILD_A;
        end
      end
      ST_QUERY_B: begin
        re        = 1'b1;
        raddr     = {lvl_r, idx_r};
        a_nxt     = rdata;
        state_nxt = ST_QUERY_C;
      end
      ST_QUERY_C: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = rmq_pkg::smaller(a_r, rdata);
          out_err_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lvl_r     <= lvl_nxt;
    idx_r     <= idx_nxt;
    span_r    <= span_nxt;
    a_r       <= a_nxt;
    out_min_r <= out_min_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_min_r;
  assign out_tuser        = out_err_r;
  assign stat.building    = (state_r == ST_BUILD_A) || (state_r == ST_BUILD_B) ||
                            (state_r == ST_BUILD_W);
  assign stat.table_ready = ready_r;

endmodule

### hw/rtl/sparse_table_range_minimum.sv
// Top level of the sparse table range-minimum block.
// Depends on rmq_pkg, rmq_front, rmq_back and sparse_table_range_minimum_defines.svh.
//
//   channel   direction  tdata                              tuser          tlast
//   in_       slave      [15:0] element, [25:16] left,      [0] operation  last element
//                        [35:26] right, [39:36] zero
//   out_      master     [15:0] range minimum               [0] error      -
//
// In the execution side a load writes one element into level 0; a query makes two
// table reads on the RAM read port, then the compare. After the last load the
// build reads two entries and writes their minimum per table entry, over all levels.
// Reset clears control state only; the table memory needs no clearing pass.
// A two-entry queue keeps accepting requests, until it is full, while the execution
// side builds or waits for the result register to drain.
`include "sparse_table_range_minimum_defines.svh"

module sparse_table_range_minimum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rmq_pkg::IN_DATA_W-1:0]   in_tdata,   // element_value, left_index, right_index
  input  logic                            in_tuser,   // operation
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rmq_pkg::OUT_DATA_W-1:0]  out_tdata,  // range_minimum
  output logic                            out_tuser   // range_error
);

  logic                cmd_valid;
  logic                cmd_pop;
  rmq_pkg::rmq_cmd_t   cmd;
  rmq_pkg::rmq_stat_t  stat;

  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rmq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (stat)
  );

  `RMQ_ASSERT(a_pop_has_cmd, cmd_pop |-> cmd_valid, "pop from empty queue")
  `RMQ_ASSERT(a_no_pop_building, stat.building |-> !cmd_pop, "request taken during build")
  `RMQ_ASSERT(a_err_zero, out_tvalid && out_tuser |-> out_tdata == '0, "error result not zero")
  `RMQ_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

### tb/rmq_min_checker.sv
// Stream-side checker for sparse_table_range_minimum: mirrors the loaded array,
// predicts the answer to every accepted query and compares results in order.
// Depends on rmq_pkg; reports its failure count and the number of answers due.
module rmq_min_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [rmq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [rmq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEFT_LSB  = rmq_pkg::VALUE_W;
  localparam int RIGHT_LSB = rmq_pkg::VALUE_W + rmq_pkg::IDX_W;

  typedef struct {
    logic signed [rmq_pkg::VALUE_W-1:0] minimum;
    logic                               flagged;
  } answer_t;

  logic signed [rmq_pkg::VALUE_W-1:0] shadow_elems [rmq_pkg::MAX_ELEMENTS];
  int unsigned                        shadow_count = 0;
  bit                                 shadow_built = 1'b0;
  answer_t                            pending_answers [$];
  int                                 fails = 0;

  // Plain scan over the range; same answer as the two overlapping table windows.
  function automatic answer_t range_min_of(int unsigned lo, int unsigned hi);
    answer_t     ans;
    int unsigned span;
    int unsigned lvl;
    ans.minimum = '0;
    ans.flagged = 1'b1;
    if (shadow_built && lo <= hi && hi < shadow_count) begin
      span = hi - lo + 1;
      lvl = 0;
      while (span > 1) begin
        span = span >> 1;
        lvl++;
      end
      if (lvl < rmq_pkg::LEVEL_COUNT) begin
        ans.minimum = shadow_elems[lo[rmq_pkg::IDX_W-1:0]];
        for (int unsigned k = lo + 1; k <= hi; k++) begin
          if (shadow_elems[k[rmq_pkg::IDX_W-1:0]] < ans.minimum) begin
            ans.minimum = shadow_elems[k[rmq_pkg::IDX_W-1:0]];
          end
        end
        ans.flagged = 1'b0;
      end
    end
    return ans;
  endfunction

  function automatic void note_load(logic signed [rmq_pkg::VALUE_W-1:0] value,
                                    logic last);
    if (shadow_built) begin
      shadow_built = 1'b0;
      shadow_count = 0;
    end
    if (shadow_count < rmq_pkg::MAX_ELEMENTS) begin
      shadow_elems[shadow_count[rmq_pkg::IDX_W-1:0]] = value;
      shadow_count++;
    end
    if (last) shadow_built = 1'b1;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_built = 1'b0;
      pending_answers.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == rmq_pkg::OP_LOAD) begin
          note_load(in_tdata[rmq_pkg::VALUE_W-1:0], in_tlast);
        end else begin
          pending_answers.insert(pending_answers.size(),
                                 range_min_of(32'(in_tdata[LEFT_LSB +: rmq_pkg::IDX_W]),
                                              32'(in_tdata[RIGHT_LSB +: rmq_pkg::IDX_W])));
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result, minimum %0d error %0b", $time,
                   $signed(out_tdata), out_tuser);
          fails++;
        end else begin
          want = pending_answers.pop_front();
          if (out_tdata !== want.minimum) begin
            $display("%0t: range minimum mismatch, expected %0d got %0d", $time,
                     want.minimum, $signed(out_tdata));
            fails++;
          end
          if (out_tuser !== want.flagged) begin
            $display("%0t: range error flag mismatch, expected %0b got %0b", $time,
                     want.flagged, out_tuser);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    answers_due <= pending_answers.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top for sparse_table_range_minimum: clock, reset, load and query
// stimulus with random idling on both streams, and the final verdict.
// Depends on rmq_pkg, the block's RTL and rmq_min_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL = 1650;
  localparam int HOLD_CYCLES = 400;
  localparam logic [rmq_pkg::VALUE_W-1:0] MOST_NEG = {1'b1, {(rmq_pkg::VALUE_W-1){1'b0}}};
  localparam logic [rmq_pkg::VALUE_W-1:0] MOST_POS = {1'b0, {(rmq_pkg::VALUE_W-1){1'b1}}};
  localparam logic [rmq_pkg::VALUE_W-1:0] MINUS_ONE = '1;
  localparam logic [rmq_pkg::IDX_W-1:0] TOP_IDX = '1;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [rmq_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [rmq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  int fail_count;
  int answers_due;

  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int n_items = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_builds = 0;
  int n_drains = 0;
  int biggest = 0;
  int held = 0;
  bit built = 1'b0;

  always #5 clk = ~clk;

  sparse_table_range_minimum uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rmq_min_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  // in_tdata: [15:0] element, [25:16] left, [35:26] right, rest zero
  task automatic send_request(input logic op, input logic [rmq_pkg::VALUE_W-1:0] value,
                              input logic last, input logic [rmq_pkg::IDX_W-1:0] lo,
                              input logic [rmq_pkg::IDX_W-1:0] hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= rmq_pkg::IN_DATA_W'({hi, lo, value});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic load_element(input logic [rmq_pkg::VALUE_W-1:0] value, input logic last);
    if (built) begin
      built = 1'b0;
      held = 0;
    end
    if (held < rmq_pkg::MAX_ELEMENTS) held++;
    if (last) begin
      built = 1'b1;
      n_builds++;
    end
    n_loads++;
    send_request(rmq_pkg::OP_LOAD, value, last, rmq_pkg::IDX_W'($urandom),
                 rmq_pkg::IDX_W'($urandom));
  endtask

  task automatic ask_range(input logic [rmq_pkg::IDX_W-1:0] lo,
                           input logic [rmq_pkg::IDX_W-1:0] hi);
    n_queries++;
    send_request(rmq_pkg::OP_QUERY, rmq_pkg::VALUE_W'($urandom),
                 1'($urandom_range(0, 1)), lo, hi);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    n_drains++;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
  endtask

  function automatic logic [rmq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return MINUS_ONE;
      default: return rmq_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  // Mostly in-range queries, with a share of bad ranges and raw noise.
  task automatic ask_mixed();
    int          kind;
    int unsigned lo;
    int unsigned hi;
    kind = (held == 0) ? 18 : $urandom_range(0, 19);
    case (kind)
      0, 1: begin
        lo = 0;
        hi = held - 1;
      end
      2, 3: begin
        lo = $urandom_range(0, held - 1);
        hi = lo;
      end
      4, 5, 6, 7: begin
        lo = $urandom_range(0, held - 1);
        hi = lo + $urandom_range(0, 7);
        if (hi > held - 1) hi = held - 1;
      end
      8, 9, 10, 11, 12, 13, 14, 15: begin
        lo = $urandom_range(0, held - 1);
        hi = $urandom_range(lo, held - 1);
      end
      16: begin
        if (held > 1) begin
          lo = $urandom_range(1, held - 1);
          hi = $urandom_range(0, lo - 1);
        end else begin
          lo = 1;
          hi = 0;
        end
      end
      17: begin
        hi = (held < rmq_pkg::MAX_ELEMENTS) ? held : rmq_pkg::MAX_ELEMENTS - 1;
        lo = $urandom_range(0, hi);
      end
      default: begin
        lo = $urandom_range(0, TOP_IDX);
        hi = $urandom_range(0, TOP_IDX);
      end
    endcase
    ask_range(rmq_pkg::IDX_W'(lo), rmq_pkg::IDX_W'(hi));
  endtask

  task automatic run_array(input int size, input bit with_last, input int queries,
                           input bit with_hold);
    if (size > biggest) biggest = size;
    for (int k = 0; k < size; k++) begin
      if ($urandom_range(0, 32) == 0) ask_mixed();
      load_element(pick_value(), with_last && (k == size - 1));
    end
    if (with_hold) hold_req = 1'b1;
    for (int q = 0; q < queries; q++) ask_mixed();
  endtask

  // result side: random ready patterns, plus one long hold-off on request
  initial begin
    int mode;
    int stretch;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(16, 160);
      repeat (stretch) begin
        if (hold_req && !hold_done) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[sparse_table_range_minimum] ERROR");
    $finish;
  end

  initial begin
    int sel;
    int size;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= rmq_pkg::OP_LOAD;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    ask_range(0, 0);
    load_element(MOST_POS, 1'b0);
    ask_range(0, 0);
    load_element(MOST_NEG, 1'b0);
    load_element('0, 1'b0);
    load_element(MINUS_ONE, 1'b0);
    load_element(rmq_pkg::VALUE_W'(1), 1'b1);
    ask_range(0, 4);
    ask_range(2, 2);
    ask_range(3, 4);
    ask_range(0, 0);
    ask_range(1, 3);
    ask_range(4, 3);
    ask_range(0, 5);
    ask_range(TOP_IDX, TOP_IDX);
    ask_range(0, TOP_IDX);
    load_element(rmq_pkg::VALUE_W'(-5), 1'b1);
    ask_range(0, 0);
    ask_range(0, 1);
    drain_results();

    // one element past a full array is dropped; the build still runs
    run_array(rmq_pkg::MAX_ELEMENTS + 1, 1'b1, 20, 1'b0);
    ask_range(TOP_IDX, TOP_IDX);
    ask_range(0, TOP_IDX);
    ask_range(TOP_IDX - 1'b1, TOP_IDX);
    drain_results();

    gaps_on = 1'b0;
    run_array(8, 1'b1, 24, 1'b1);
    drain_results();

    while (n_items < ITEM_GOAL) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 70) size = $urandom_range(1, 16);
      else if (sel < 90) size = $urandom_range(17, 128);
      else if (sel < 98) size = $urandom_range(129, 400);
      else size = $urandom_range(rmq_pkg::MAX_ELEMENTS - 4, rmq_pkg::MAX_ELEMENTS + 6);
      run_array(size, $urandom_range(0, 19) != 0, $urandom_range(4, 40), 1'b0);
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (100) @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d loads and %0d range queries over %0d table builds,",
             n_loads, n_queries, n_builds);
    $display("largest array %0d elements, %0d full drains, one long result hold-off.",
             biggest, n_drains);
    if (fail_count == 0) begin
      $display("[sparse_table_range_minimum] OK");
    end else begin
      $display("[sparse_table_range_minimum] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_ram.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_back.sv
hw/rtl/sparse_table_range_minimum.sv
tb/rmq_min_checker.sv
tb/tb_top.sv
